// ===== hw/rtl/abp_pkg.sv =====
// Shared types, constants and fixed-point helpers of the binomial option pricer.
`default_nettype none

package abp_pkg;

    localparam int ABP_MAX_STEPS = 1023;
    localparam int TREE_STEPS_W = 10;
    localparam logic [TREE_STEPS_W-1:0] TREE_STEPS_RESET = 10'd64;

    localparam logic [30:0] ABP_Q30_ONE = 31'h4000_0000;
    localparam logic [63:0] ABP_Q30_HALF = 64'h0000_0000_2000_0000;

    localparam logic OPT_PUT = 1'b0;
    localparam logic OPT_CALL = 1'b1;

    // Per-item operands that the node pipeline needs for every node.
    typedef struct packed {
        logic [31:0] strike;
        logic [30:0] prob;
        logic [30:0] disc;
        logic        kind;
    } t_job;

    // Control of one issue slot of the node pipeline.
    typedef struct packed {
        logic valid;
        logic leaf;
        logic prime;
    } t_issue;

    // Status returned by the node pipeline.
    typedef struct packed {
        logic busy;
        logic sat;
    } t_pipe_stat;

    // Round half up a Q2.30 product, shift by 30 and saturate to 32 bits.
    // Bit 32 of the result tells that saturation took place.
    function automatic logic [32:0] q30_round_sat(input logic [63:0] prod);
        logic [64:0] t;
        t = {1'b0, prod} + {1'b0, ABP_Q30_HALF};
        if (|t[64:62]) begin
            return {1'b1, 32'hFFFF_FFFF};
        end
        return {1'b0, t[61:30]};
    endfunction

    // Early-exercise value, never below zero.
    function automatic logic [31:0] exercise_value(input logic [31:0] s,
                                                   input logic [31:0] k,
                                                   input logic kind);
        if (kind == OPT_CALL) begin
            return (s > k) ? (s - k) : 32'd0;
        end
        return (k > s) ? (k - s) : 32'd0;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/abp_if.sv =====
// Valid/ready channel interfaces for option items and price results.
`default_nettype none

interface abp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] spot;
    logic [31:0] strike;
    logic [31:0] up_factor;
    logic [31:0] down_factor;
    logic [30:0] up_prob;
    logic [30:0] discount;
    logic        option_kind;

    modport source(output valid, spot, strike, up_factor, down_factor, up_prob, discount,
                   option_kind, input ready);
    modport sink(input valid, spot, strike, up_factor, down_factor, up_prob, discount,
                 option_kind, output ready);
endinterface

interface abp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] price;
    logic        saturated;

    modport source(output valid, price, saturated, input ready);
    modport sink(input valid, price, saturated, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/american_option_binomial_pricer.sv =====
// Top level of the binomial-tree American option pricer.
`default_nettype none

// Prices one American put or call per input beat on a recombining binomial
// tree of N steps, N taken from the tree_steps register (clamped to MAX_STEPS)
// at the time the beat is accepted. Software supplies the up and down factors,
// the up probability and the per-step discount in Q2.30; prices are unsigned
// Q16.16. The block works on one option at a time. It first builds the tables
// spot*up^k and down^k, for each step multiplying the running powers and then
// writing the rounded products, then writes the N+1 leaves, one per cycle,
// then walks the tree back level by level through the node pipeline, which
// reads and rewrites one entry of the node memory per cycle while a level is
// being walked. A level may only start once the previous one has been written
// back, so a pipeline drain and a priming read lie between levels. The run
// time is set by the single node pipeline and the one read port of the node
// memory. The result beat waits in an output register, and the next option is
// accepted while it waits. Configuration may only be written while no option
// is in flight. The saturated flag reports that some power or node price
// product was clipped to 2^32-1.
module american_option_binomial_pricer #(
    parameter int MAX_STEPS = abp_pkg::ABP_MAX_STEPS,
    localparam int AW = $clog2(MAX_STEPS + 1)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [abp_pkg::TREE_STEPS_W-1:0]   i_cfg_data,
    abp_in_if.sink                                  i_in,
    abp_out_if.source                               o_res
);

    import abp_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_POW0   = 4'd1;
    localparam logic [3:0] ST_POWMUL = 4'd2;
    localparam logic [3:0] ST_POWWR  = 4'd3;
    localparam logic [3:0] ST_LEAF   = 4'd4;
    localparam logic [3:0] ST_DRAIN  = 4'd5;
    localparam logic [3:0] ST_PRIME  = 4'd6;
    localparam logic [3:0] ST_LEVEL  = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    logic [3:0]              r_state;
    logic [TREE_STEPS_W-1:0] r_tree_steps;
    logic [AW-1:0]           r_n;
    logic [AW-1:0]           r_j;
    logic [AW-1:0]           r_lvl;
    logic                    r_more;
    logic [31:0]             r_spot;
    logic [31:0]             r_upf;
    logic [31:0]             r_dnf;
    logic [31:0]             r_u;
    logic [31:0]             r_d;
    logic [63:0]             r_pu;
    logic [63:0]             r_pd;
    t_job                    r_job;
    logic                    r_sat;
    logic                    r_out_valid;
    logic [31:0]             r_out_price;
    logic                    r_out_sat;

    logic          w_accept;
    logic [AW-1:0] w_n;
    logic [32:0]   w_ru;
    logic [32:0]   w_rd;
    logic          w_pow_we;
    logic [AW-1:0] w_pow_waddr;
    logic [31:0]   w_pow_up;
    logic [31:0]   w_pow_dn;
    t_issue        w_ctl;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_up_addr;
    logic [AW-1:0] w_dn_addr;
    t_pipe_stat    w_stat;
    logic [31:0]   w_root;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept = i_in.valid && i_in.ready;

    // Tree depth, clamped to what the memories hold.
    assign w_n = (32'(r_tree_steps) > 32'(MAX_STEPS)) ? AW'(MAX_STEPS) : AW'(r_tree_steps);

    assign w_ru = q30_round_sat(r_pu);
    assign w_rd = q30_round_sat(r_pd);

    // Power table writes: entry zero holds spot and one, later entries the
    // rounded products of the running powers.
    always_comb begin
        w_pow_we    = 1'b0;
        w_pow_waddr = r_j;
        w_pow_up    = w_ru[31:0];
        w_pow_dn    = w_rd[31:0];
        if (r_state == ST_POW0) begin
            w_pow_we    = 1'b1;
            w_pow_waddr = '0;
            w_pow_up    = r_spot;
            w_pow_dn    = 32'(ABP_Q30_ONE);
        end else if (r_state == ST_POWWR) begin
            w_pow_we = 1'b1;
        end
    end

    // Issue slot of the node pipeline. A leaf at column j uses the power
    // pair (N-j, j); an inner node of level L uses (L-j, j) and the children
    // j and j+1, of which only j+1 is read since j came with the previous node.
    always_comb begin
        w_ctl     = '0;
        w_rd_addr = r_j + AW'(1);
        w_up_addr = r_lvl - r_j;
        w_dn_addr = r_j;
        unique case (r_state)
            ST_LEAF: begin
                w_ctl.valid = 1'b1;
                w_ctl.leaf  = 1'b1;
                w_up_addr   = r_n - r_j;
            end
            ST_PRIME: begin
                w_ctl.valid = 1'b1;
                w_ctl.prime = 1'b1;
                w_rd_addr   = '0;
            end
            ST_LEVEL: begin
                w_ctl.valid = 1'b1;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    abp_node_pipe #(.MAX_STEPS(MAX_STEPS)) u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pow_we   (w_pow_we),
        .i_pow_waddr(w_pow_waddr),
        .i_pow_up   (w_pow_up),
        .i_pow_dn   (w_pow_dn),
        .i_ctl      (w_ctl),
        .i_rd_addr  (w_rd_addr),
        .i_up_addr  (w_up_addr),
        .i_dn_addr  (w_dn_addr),
        .i_wr_addr  (r_j),
        .i_job      (r_job),
        .o_stat     (w_stat),
        .o_root     (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_steps <= TREE_STEPS_RESET;
        end else if (i_cfg_we) begin
            r_tree_steps <= i_cfg_data;
        end
    end

    // Sequencer: power tables, leaves, then one level after another.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_sat       <= 1'b0;
            r_more      <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_stat.sat) begin
                r_sat <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_sat   <= 1'b0;
                        r_state <= ST_POW0;
                    end
                end
                ST_POW0: begin
                    r_j <= AW'(1);
                    r_u <= r_spot;
                    r_d <= 32'(ABP_Q30_ONE);
                    r_state <= (r_n == '0) ? ST_LEAF : ST_POWMUL;
                    if (r_n == '0) begin
                        r_j <= '0;
                    end
                end
                ST_POWMUL: begin
                    r_pu    <= 64'(r_u) * 64'(r_upf);
                    r_pd    <= 64'(r_d) * 64'(r_dnf);
                    r_state <= ST_POWWR;
                end
                ST_POWWR: begin
                    r_u <= w_ru[31:0];
                    r_d <= w_rd[31:0];
                    if (w_ru[32] || w_rd[32]) begin
                        r_sat <= 1'b1;
                    end
                    if (r_j == r_n) begin
                        r_j     <= '0;
                        r_state <= ST_LEAF;
                    end else begin
                        r_j     <= r_j + AW'(1);
                        r_state <= ST_POWMUL;
                    end
                end
                ST_LEAF: begin
                    if (r_j == r_n) begin
                        r_lvl   <= r_n - AW'(1);
                        r_more  <= (r_n != '0);
                        r_state <= ST_DRAIN;
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!w_stat.busy) begin
                        r_j     <= '0;
                        r_state <= r_more ? ST_PRIME : ST_FINISH;
                    end
                end
                ST_PRIME: begin
                    r_state <= ST_LEVEL;
                end
                ST_LEVEL: begin
                    if (r_j == r_lvl) begin
                        r_more  <= (r_lvl != '0);
                        r_lvl   <= r_lvl - AW'(1);
                        r_state <= ST_DRAIN;
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                ST_FINISH: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Operand capture and result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_n          <= w_n;
            r_spot       <= i_in.spot;
            r_upf        <= i_in.up_factor;
            r_dnf        <= i_in.down_factor;
            r_job.strike <= i_in.strike;
            r_job.prob   <= (i_in.up_prob > ABP_Q30_ONE) ? ABP_Q30_ONE : i_in.up_prob;
            r_job.disc   <= (i_in.discount > ABP_Q30_ONE) ? ABP_Q30_ONE : i_in.discount;
            r_job.kind   <= i_in.option_kind;
        end
        if ((r_state == ST_FINISH) && (!r_out_valid || o_res.ready)) begin
            r_out_price <= w_root;
            r_out_sat   <= r_sat;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.price     = r_out_price;
    assign o_res.saturated = r_out_sat;

endmodule

`default_nettype wire

// ===== hw/rtl/abp_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module abp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/abp_node_pipe.sv =====
// Node pipeline: power tables, node value memory and the per-node datapath.
`default_nettype none

module abp_node_pipe #(
    parameter int MAX_STEPS = abp_pkg::ABP_MAX_STEPS,
    localparam int DEPTH = MAX_STEPS + 1,
    localparam int AW = $clog2(MAX_STEPS + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_pow_we,
    input  wire logic [AW-1:0]       i_pow_waddr,
    input  wire logic [31:0]         i_pow_up,
    input  wire logic [31:0]         i_pow_dn,
    input  wire abp_pkg::t_issue     i_ctl,
    input  wire logic [AW-1:0]       i_rd_addr,
    input  wire logic [AW-1:0]       i_up_addr,
    input  wire logic [AW-1:0]       i_dn_addr,
    input  wire logic [AW-1:0]       i_wr_addr,
    input  wire abp_pkg::t_job       i_job,
    output abp_pkg::t_pipe_stat      o_stat,
    output logic [31:0]              o_root
);

    import abp_pkg::*;

    logic [31:0] w_vnew;
    logic [31:0] w_u;
    logic [31:0] w_d;
    logic [30:0] w_q;
    logic [63:0] w_acc;
    logic [32:0] w_rs;
    logic [31:0] w_e;
    logic [31:0] w_x;
    logic [31:0] w_c;
    logic [31:0] w_val;

    logic          r_s1_valid, r_s1_leaf, r_s1_prime;
    logic [AW-1:0] r_s1_addr;
    logic [31:0]   r_vprev;
    logic          r_s2_valid, r_s2_leaf;
    logic [AW-1:0] r_s2_addr;
    logic [63:0]   r_m1, r_m2, r_m3;
    logic          r_s3_valid, r_s3_leaf, r_sat3;
    logic [AW-1:0] r_s3_addr;
    logic [31:0]   r_e, r_x3;
    logic          r_s4_valid, r_s4_leaf;
    logic [AW-1:0] r_s4_addr;
    logic [63:0]   r_m4;
    logic [31:0]   r_x4;

    abp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (r_s4_valid),
        .i_waddr(r_s4_addr),
        .i_wdata(w_val),
        .i_raddr(i_rd_addr),
        .o_rdata(w_vnew)
    );

    abp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_up_ram (
        .i_clk  (i_clk),
        .i_we   (i_pow_we),
        .i_waddr(i_pow_waddr),
        .i_wdata(i_pow_up),
        .i_raddr(i_up_addr),
        .o_rdata(w_u)
    );

    abp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_dn_ram (
        .i_clk  (i_clk),
        .i_we   (i_pow_we),
        .i_waddr(i_pow_waddr),
        .i_wdata(i_pow_dn),
        .i_raddr(i_dn_addr),
        .o_rdata(w_d)
    );

    assign w_q = ABP_Q30_ONE - i_job.prob;

    // The continuation sum stays below 2^62, so the shifted value fits 32 bits.
    assign w_acc = r_m1 + r_m2 + ABP_Q30_HALF;
    assign w_e = w_acc[61:30];
    assign w_rs = q30_round_sat(r_m3);
    assign w_x = exercise_value(w_rs[31:0], i_job.strike, i_job.kind);

    assign w_c = 32'((r_m4 + ABP_Q30_HALF) >> 30);
    assign w_val = (r_s4_leaf || (r_x4 > w_c)) ? r_x4 : w_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_ctl.valid;
            r_s2_valid <= r_s1_valid && !r_s1_prime;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_leaf  <= i_ctl.leaf;
        r_s1_prime <= i_ctl.prime;
        r_s1_addr  <= i_wr_addr;

        // The right child of one node is the left child of the next one.
        if (r_s1_valid) begin
            r_vprev <= w_vnew;
        end
        r_m1      <= 64'(i_job.prob) * 64'(r_vprev);
        r_m2      <= 64'(w_q) * 64'(w_vnew);
        r_m3      <= 64'(w_u) * 64'(w_d);
        r_s2_leaf <= r_s1_leaf;
        r_s2_addr <= r_s1_addr;

        r_e       <= w_e;
        r_x3      <= w_x;
        r_sat3    <= w_rs[32];
        r_s3_leaf <= r_s2_leaf;
        r_s3_addr <= r_s2_addr;

        r_m4      <= 64'(r_e) * 64'(i_job.disc);
        r_x4      <= r_x3;
        r_s4_leaf <= r_s3_leaf;
        r_s4_addr <= r_s3_addr;

        if (r_s4_valid) begin
            o_root <= w_val;
        end
    end

    assign o_stat.busy = r_s1_valid || r_s2_valid || r_s3_valid || r_s4_valid;
    assign o_stat.sat = r_s3_valid && r_sat3;

endmodule

`default_nettype wire
